FILE: src/indexed_list_engine_defines.svh
// ----------------------------------------------------------------------------
// indexed_list_engine_defines
// assertion macros used by the list engine
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ILE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ILE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg
// types and codes of the indexed list engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ile_pkg;

  // operation codes
  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_SET    = 3'd3,
    OP_GET    = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INS_WR,
    ST_GET_WAIT,
    ST_FINISH
  } state_e;

  // request payload
  typedef struct packed {
    logic [2:0]         op;
    logic [5:0]         position;
    logic signed [31:0] value;
  } ile_in_t;

  // result payload
  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [6:0]         count;
  } ile_out_t;

endpackage

FILE: src/ile_ram.sv
// ----------------------------------------------------------------------------
// ile_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ile_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: src/indexed_list_engine.sv
// ----------------------------------------------------------------------------
// indexed_list_engine
// bounded ordered list with append, insert, delete, set and get
// ----------------------------------------------------------------------------
// Requests come in on in_data_i and transfer when in_valid_i is high and
// in_stall_o is low; each request gives exactly one result on out_data_o,
// which transfers when out_valid_o is high and out_stall_i is low.
// Items live in a single RAM with one write and one registered read port.
// A small sequencer steps one index counter up or down and moves one entry
// at a time (read, then write) through that RAM. The block takes one
// request at a time; in_stall_o is high from accept until the result is
// loaded into the output register. A result waiting under out_stall_i does
// not block the next request, but the one after it waits until the output
// register frees up. Reset empties the list (count zero) and drops any
// pending result; the RAM contents are not cleared, only entries below
// the count are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "indexed_list_engine_defines.svh"

module indexed_list_engine #(
  parameter int CAPACITY  = 64,
  parameter int ITEM_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ile_pkg::ile_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ile_pkg::ile_out_t out_data_o
);

  import ile_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     res_cnt_q, res_cnt_d;
  status_e              res_st_q, res_st_d;
  logic signed [31:0]   res_val_q, res_val_d;
  logic [2:0]           op_q;
  logic [5:0]           pos_q;
  logic [ITEM_BITS-1:0] item_q;
  logic                 up_q, up_d;
  logic                 out_valid_q, out_valid_d;
  ile_out_t             out_q;

  logic                 accept;
  logic                 out_free;
  logic                 load_res;
  logic                 shifting;
  logic                 pos_ok;
  logic                 is_full;
  logic [CNT_W-1:0]     step;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [ITEM_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [ITEM_BITS-1:0] ram_rdata;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_res   = (state_q == ST_FINISH) && out_free;
  assign shifting   = (state_q == ST_SHIFT_RD) || (state_q == ST_SHIFT_WR);

  // shared index step unit and range compares
  assign step    = up_q ? (idx_q + CNT_W'(1)) : (idx_q - CNT_W'(1));
  assign pos_ok  = CMP_W'(pos_q) < CMP_W'(count_q);
  assign is_full = (count_q == CNT_W'(CAPACITY));

  // item storage
  ile_ram #(
    .WIDTH (ITEM_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer next state and datapath control
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    up_d      = up_q;
    res_cnt_d = res_cnt_q;
    res_st_d  = res_st_q;
    res_val_d = res_val_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = step[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        res_cnt_d = count_q;
        res_st_d  = STAT_DONE;
        res_val_d = '0;
        state_d   = ST_FINISH;
        unique case (op_e'(op_q))
          OP_APPEND: begin
            if (is_full) begin
              res_st_d = STAT_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count_q[AW-1:0];
              ram_wdata = item_q;
              res_cnt_d = count_q + CNT_W'(1);
            end
          end
          OP_INSERT: begin
            if (!pos_ok) begin
              res_st_d = STAT_RANGE;
            end else if (is_full) begin
              res_st_d = STAT_FULL;
            end else begin
              idx_d     = count_q;
              up_d      = 1'b0;
              res_cnt_d = count_q + CNT_W'(1);
              state_d   = ST_SHIFT_RD;
            end
          end
          OP_DELETE: begin
            if (!pos_ok) begin
              res_st_d = STAT_RANGE;
            end else begin
              idx_d     = CNT_W'(pos_q);
              up_d      = 1'b1;
              res_cnt_d = count_q - CNT_W'(1);
              // last entry removed: nothing to move
              if (CMP_W'(pos_q) != CMP_W'(count_q - CNT_W'(1))) begin
                state_d = ST_SHIFT_RD;
              end
            end
          end
          OP_SET: begin
            if (!pos_ok) begin
              res_st_d = STAT_RANGE;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = AW'(pos_q);
              ram_wdata = item_q;
            end
          end
          OP_GET: begin
            if (!pos_ok) begin
              res_st_d = STAT_RANGE;
            end else begin
              ram_raddr = AW'(pos_q);
              state_d   = ST_GET_WAIT;
            end
          end
          default: begin
          end
        endcase
      end

      // fetch the neighbor entry that moves into idx
      ST_SHIFT_RD: begin
        state_d = ST_SHIFT_WR;
      end

      // move it and step the index
      ST_SHIFT_WR: begin
        ram_we = 1'b1;
        idx_d  = step;
        if (up_q) begin
          state_d = (step < res_cnt_q) ? ST_SHIFT_RD : ST_FINISH;
        end else begin
          state_d = (CMP_W'(step) > CMP_W'(pos_q)) ? ST_SHIFT_RD : ST_INS_WR;
        end
      end

      // new item lands in the freed slot
      ST_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(pos_q);
        ram_wdata = item_q;
        state_d   = ST_FINISH;
      end

      ST_GET_WAIT: begin
        res_val_d = 32'({{64{ram_rdata[ITEM_BITS-1]}}, ram_rdata});
        state_d   = ST_FINISH;
      end

      ST_FINISH: begin
        if (out_free) begin
          count_d = res_cnt_q;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_res) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request and working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_data_i.op;
      pos_q  <= in_data_i.position;
      item_q <= ITEM_BITS'({{32{in_data_i.value[31]}}, in_data_i.value});
    end
    idx_q     <= idx_d;
    up_q      <= up_d;
    res_cnt_q <= res_cnt_d;
    res_st_q  <= res_st_d;
    res_val_q <= res_val_d;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load_res) begin
      out_q.read_value <= res_val_q;
      out_q.status     <= res_st_q;
      out_q.count      <= 7'(res_cnt_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `ILE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY), "count above capacity")
  `ILE_ASSERT_NEXT(a_count_hold, state_q != ST_FINISH, $stable(count_q), "count moved mid-op")
  `ILE_ASSERT_NEXT(a_result_load, load_res, out_valid_q && state_q == ST_IDLE, "result not loaded")
  `ILE_ASSERT_NOW(a_shift_idx, shifting, idx_q < CNT_W'(CAPACITY), "shift index out of range")

endmodule
